FILE: sv/uer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

  // Sequencer timing, in ticks
  localparam int unsigned PT_W = 4;
  localparam logic [PT_W-1:0] PRE_LOW_TICKS = 4'd2;
  localparam logic [PT_W-1:0] TRIGGER_TICKS = 4'd10;

  // Echo counter and arithmetic widths
  localparam int unsigned COUNT_W   = 24;
  localparam int unsigned HALF_W    = COUNT_W - 1;
  localparam int unsigned SPEED_W   = 17;
  localparam int unsigned TIMEOUT_W = 23;
  localparam int unsigned DIST_W    = 32;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned CMP_W     = (HALF_W > TIMEOUT_W) ? HALF_W : TIMEOUT_W;
  localparam int unsigned PROD_W    = HALF_W + SPEED_W;
  localparam int unsigned SHX_W     = (PROD_W - FRAC_W > DIST_W + 1) ?
                                      (PROD_W - FRAC_W) : (DIST_W + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 23;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b1;
  localparam logic [SPEED_W-1:0]   SPEED_RESET   = 17'd87808;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 23'd38000;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_USED_W  = 3 + DIST_W;

  // Sequencer result handed to the range stage
  typedef struct packed {
    logic              trig;
    logic              done;
    logic              far;
    logic [HALF_W-1:0] half;
  } uer_ctl_t;

endpackage

`default_nettype wire

FILE: sv/uer_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Trigger / echo sequencer. Updates phase on every accepted item and registers
// the per-item control result.
module uer_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           take_i,
  input  wire logic                           cmd_i,
  input  wire logic                           echo_i,
  input  wire logic [uer_pkg::TIMEOUT_W-1:0]  timeout_i,
  output uer_pkg::uer_ctl_t                   ctl_o
);
  import uer_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_PRELOW = 3'd1;
  localparam logic [2:0] PH_TRIG   = 3'd2;
  localparam logic [2:0] PH_WAIT   = 3'd3;
  localparam logic [2:0] PH_ECHO   = 3'd4;

  logic [2:0]         phase_q, phase_d;
  logic [PT_W-1:0]    pt_q, pt_d, pt_inc;
  logic [COUNT_W-1:0] et_q, et_d;
  logic [HALF_W-1:0]  half_raw;
  uer_ctl_t           ctl_q, ctl_d;

  assign pt_inc   = pt_q + PT_W'(1);
  assign half_raw = et_q[COUNT_W-1:1];

  always_comb begin
    phase_d = phase_q;
    pt_d    = pt_q;
    et_d    = et_q;
    ctl_d   = '0;
    if (cmd_i) begin
      phase_d = PH_PRELOW;
      pt_d    = '0;
      et_d    = '0;
    end else begin
      unique case (phase_q)
        PH_IDLE: ;
        PH_PRELOW: begin
          pt_d = pt_inc;
          if (pt_inc >= PRE_LOW_TICKS) begin
            phase_d    = PH_TRIG;
            pt_d       = '0;
            ctl_d.trig = 1'b1;
          end
        end
        PH_TRIG: begin
          pt_d = pt_inc;
          if (pt_inc >= TRIGGER_TICKS) begin
            phase_d = PH_WAIT;
            pt_d    = '0;
          end else begin
            ctl_d.trig = 1'b1;
          end
        end
        PH_WAIT: begin
          if (echo_i) begin
            phase_d = PH_ECHO;
            et_d    = COUNT_W'(1);
          end
        end
        PH_ECHO: begin
          if (echo_i) begin
            // counter sticks at all ones
            if (!(&et_q)) et_d = et_q + COUNT_W'(1);
          end else begin
            ctl_d.done = 1'b1;
            if (CMP_W'(half_raw) > CMP_W'(timeout_i)) begin
              ctl_d.far = 1'b1;
            end else begin
              ctl_d.half = half_raw;
            end
            phase_d = PH_IDLE;
            et_d    = '0;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          pt_d    = '0;
          et_d    = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pt_q    <= '0;
      et_q    <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      pt_q    <= pt_d;
      et_q    <= et_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) ctl_q <= ctl_d;
  end

  assign ctl_o = ctl_q;

endmodule

`default_nettype wire

FILE: sv/uer_range.sv
`timescale 1ns / 1ps
`default_nettype none

// Distance stage: half count times speed, drop fraction, saturate to 32 bits.
module uer_range (
  input  wire logic                          clk_i,
  input  wire logic                          load_i,
  input  uer_pkg::uer_ctl_t                  ctl_i,
  input  wire logic [uer_pkg::SPEED_W-1:0]   speed_i,
  output logic [uer_pkg::OUT_USED_W-1:0]     res_o
);
  import uer_pkg::*;

  logic [PROD_W-1:0]        prod;
  logic [SHX_W-1:0]         shifted;
  logic [DIST_W-1:0]        dist_sat;
  logic [OUT_USED_W-1:0]    res_q;

  // half is zero unless done and within timeout, so dist_sat is zero otherwise
  assign prod     = PROD_W'(ctl_i.half) * PROD_W'(speed_i);
  assign shifted  = SHX_W'(prod >> FRAC_W);
  assign dist_sat = (|shifted[SHX_W-1:DIST_W]) ? '1 : shifted[DIST_W-1:0];

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= {dist_sat, ctl_i.far, ctl_i.done, ctl_i.trig};
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: sv/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps
`default_nettype none

// Ultrasonic ranging controller. Feed one item per microsecond tick
// (cmd = 0) or a start (cmd = 1), each with the sampled echo pin level; every
// item yields exactly one result carrying the trigger pin level to drive next,
// and on the item where the echo falls, done plus either a distance in
// micrometres ((echo_ticks / 2) * speed_q8 >> 8, saturated to 32 bits) or the
// too_far flag when the half count exceeds timeout_us. The block takes one item
// per clock cycle while m_axis keeps taking results; each result passes through
// the sequencer register, then the 23x17 distance multiplier register, before
// it is offered on m_axis. With m_axis stalled the two stages hold two results
// before s_axis_tready drops.
// Config writes (speed_q8 index 0, timeout_us index 1) belong between items.
module ultrasonic_echo_ranger (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [0] cmd, [1] echo_level, [7:2] zero
  input  wire logic [uer_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] trigger_level, [1] done_res, [2] too_far, [34:3] distance_um, [39:35] zero
  output logic [uer_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  input  wire logic                              cfg_we_i,
  input  wire logic [uer_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [uer_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import uer_pkg::*;

  logic [SPEED_W-1:0]    speed_q;
  logic [TIMEOUT_W-1:0]  timeout_q;
  logic                  s1_vld_q, s1_vld_d;
  logic                  out_vld_q, out_vld_d;
  logic                  out_free, s1_adv, in_take;
  uer_ctl_t              ctl;
  logic [OUT_USED_W-1:0] res;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q   <= SPEED_RESET;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_SPEED)   speed_q   <= cfg_data_i[SPEED_W-1:0];
      if (cfg_idx_i == REG_TIMEOUT) timeout_q <= cfg_data_i[TIMEOUT_W-1:0];
    end
  end

  // Two-stage flow control: each stage loads when it is empty or drains
  assign out_free      = !out_vld_q || m_axis_tready;
  assign s1_adv        = s1_vld_q && out_free;
  assign s_axis_tready = !s1_vld_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_take)     s1_vld_d = 1'b1;
    else if (s1_adv) s1_vld_d = 1'b0;
    out_vld_d = out_vld_q;
    if (s1_adv)             out_vld_d = 1'b1;
    else if (m_axis_tready) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  uer_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (in_take),
    .cmd_i     (s_axis_tdata[0]),
    .echo_i    (s_axis_tdata[1]),
    .timeout_i (timeout_q),
    .ctl_o     (ctl)
  );

  uer_range u_range (
    .clk_i   (clk_i),
    .load_i  (s1_adv),
    .ctl_i   (ctl),
    .speed_i (speed_q),
    .res_o   (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'(res);

endmodule

`default_nettype wire

FILE: sv/uer_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module uer_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  input  wire logic [uer_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import uer_pkg::*;

  // stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // no completion means no flag and no distance
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[OUT_USED_W-1:2] == '0)
    else $error("flag or distance without done");

  // too far reports zero distance
  a_far_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[OUT_USED_W-1:3] == '0)
    else $error("distance with too_far");

  // completion only happens after the trigger pulse, never with it high
  a_trig_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("trigger high on completion item");

  // pad bits are zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:OUT_USED_W] == '0)
    else $error("nonzero pad bits");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

// Ranging controller bench: one item per tick or start, one result per item.
// The driver and the monitor are clocked processes; the main initial block
// only releases reset, queues items, changes registers while the pipe is empty
// and decides how the two stream sides pace themselves.
module tb;
  import uer_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all
  localparam int unsigned LONG_HOLD      = 400;   // output hold-off that backs up the block
  localparam int unsigned ITEM_TARGET    = 1400;
  localparam int unsigned BATCH_ITEMS    = 90;    // items between register changes
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned SEQ_TICKS      = PRE_LOW_TICKS + TRIGGER_TICKS;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef enum logic [2:0] {
    RG_IDLE,
    RG_PRELOW,
    RG_TRIG,
    RG_WAIT,
    RG_ECHO
  } ranger_phase_e;

  typedef struct packed {
    logic cmd;
    logic echo;
  } tick_t;

  typedef struct packed {
    logic              trig;
    logic              done;
    logic              far;
    logic [DIST_W-1:0] dist_um;
  } reading_t;

  // ---------------------------------------------------------------------------
  // DUT connections; everything driven has a known value from time zero
  // ---------------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [0] cmd, [1] echo_level, [7:2] zero
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [0] trigger_level, [1] done_res, [2] too_far, [34:3] distance_um, [39:35] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = REG_SPEED;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  ultrasonic_echo_ranger dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  tick_t       tick_q[$];      // items waiting for the driver
  reading_t    reading_q[$];   // predicted results, oldest first
  int unsigned items_queued  = 0;
  int unsigned items_taken   = 0;
  int unsigned gap_pct       = 0;  // sender idle chance per cycle, percent
  int unsigned stall_pct     = 0;  // receiver stall chance per cycle, percent
  int unsigned hold_asks     = 0;  // bumped by the sequence to request a long hold-off
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned mismatches    = 0;
  int unsigned n_results     = 0;
  int unsigned n_starts      = 0;
  int unsigned n_done        = 0;
  int unsigned n_far         = 0;
  int unsigned n_configs     = 0;

  // Shadow of the ranger: sequencer state plus the two registers
  ranger_phase_e        rg_phase       = RG_IDLE;
  logic [PT_W-1:0]      rg_phase_ticks = '0;
  logic [COUNT_W-1:0]   rg_echo_ticks  = '0;
  logic [SPEED_W-1:0]   rg_speed       = SPEED_RESET;
  logic [TIMEOUT_W-1:0] rg_timeout     = TIMEOUT_RESET;

  // ---------------------------------------------------------------------------
  // Ranging behavior: advance the shadow by one item, return its result
  // ---------------------------------------------------------------------------
  function automatic reading_t advance_ranger(logic cmd, logic echo);
    reading_t          r;
    logic [HALF_W-1:0] half;
    logic [PROD_W-1:0] prod;
    logic [SHX_W-1:0]  scaled;
    r = '0;
    if (cmd == CMD_START) begin
      // a start always restarts, even mid-measurement
      rg_phase       = RG_PRELOW;
      rg_phase_ticks = '0;
      rg_echo_ticks  = '0;
    end else begin
      case (rg_phase)
        RG_PRELOW: begin
          rg_phase_ticks = rg_phase_ticks + 1'b1;
          if (rg_phase_ticks >= PRE_LOW_TICKS) begin
            rg_phase       = RG_TRIG;
            rg_phase_ticks = '0;
            r.trig         = 1'b1;
          end
        end
        RG_TRIG: begin
          rg_phase_ticks = rg_phase_ticks + 1'b1;
          if (rg_phase_ticks >= TRIGGER_TICKS) begin
            rg_phase       = RG_WAIT;
            rg_phase_ticks = '0;
          end else begin
            r.trig = 1'b1;
          end
        end
        RG_WAIT: begin
          // rising tick counts as the first echo tick; no time limit here
          if (echo) begin
            rg_phase      = RG_ECHO;
            rg_echo_ticks = COUNT_W'(1);
          end
        end
        RG_ECHO: begin
          if (echo) begin
            if (rg_echo_ticks != '1) rg_echo_ticks = rg_echo_ticks + 1'b1;
          end else begin
            half   = rg_echo_ticks[COUNT_W-1:1];
            r.done = 1'b1;
            if (half > rg_timeout) begin
              r.far = 1'b1;
            end else begin
              prod      = half * rg_speed;
              scaled    = SHX_W'(prod >> FRAC_W);
              r.dist_um = (scaled > {DIST_W{1'b1}}) ? '1 : scaled[DIST_W-1:0];
            end
            rg_phase      = RG_IDLE;
            rg_echo_ticks = '0;
          end
        end
        RG_IDLE: begin
        end
        default: begin
          rg_phase       = RG_IDLE;
          rg_phase_ticks = '0;
          rg_echo_ticks  = '0;
        end
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and reset (reset held low from time zero, released once)
  // ---------------------------------------------------------------------------
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Driver: holds an item until taken, random gaps only between items
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tick_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        nxt = tick_q.pop_front();
        s_axis_tdata  <= {{(IN_TDATA_W-2){1'b0}}, nxt.echo, nxt.cmd};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_asks) begin
      hold_served = hold_asks;
      hold_left   = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on input handshakes, check on output handshakes
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    reading_t want;
    reading_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = advance_ranger(s_axis_tdata[0], s_axis_tdata[1]);
        reading_q.push_back(want);
        items_taken = items_taken + 1;
        if (s_axis_tdata[0] == CMD_START) n_starts++;
        n_done += want.done;
        n_far  += want.far;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.trig    = m_axis_tdata[0];
        got.done    = m_axis_tdata[1];
        got.far     = m_axis_tdata[2];
        got.dist_um = m_axis_tdata[3 +: DIST_W];
        n_results++;
        if (reading_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d arrived with nothing pending: tdata %h",
                     n_results, m_axis_tdata);
        end else begin
          want = reading_q.pop_front();
          if (got.trig !== want.trig || got.done !== want.done ||
              got.far !== want.far || got.dist_um !== want.dist_um) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result %0d: expected trig %b done %b far %b dist %0d",
                       n_results, want.trig, want.done, want.far, want.dist_um);
              $display("  got trig %b done %b far %b dist %0d",
                       got.trig, got.done, got.far, got.dist_um);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any handshake means the block is stuck
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, reading_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence helpers
  // ---------------------------------------------------------------------------
  task automatic push_tick(logic cmd, logic echo);
    tick_t t;
    t.cmd  = cmd;
    t.echo = echo;
    tick_q.push_back(t);
    items_queued = items_queued + 1;
  endtask

  // every queued item taken and every result back: block is idle
  task automatic wait_drained();
    while (items_taken != items_queued || reading_q.size() != 0) @(posedge clk_i);
  endtask

  // both registers back to back; enable stays high across the pair
  task automatic set_config(logic [SPEED_W-1:0] spd, logic [TIMEOUT_W-1:0] tmo);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SPEED;
    cfg_data_i <= CFG_DATA_W'(spd);
    rg_speed = spd;
    @(posedge clk_i);
    cfg_idx_i  <= REG_TIMEOUT;
    cfg_data_i <= tmo;
    rg_timeout = tmo;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_configs++;
  endtask

  // start, trigger sequence with junk echo, quiet wait, echo pulse, fall
  task automatic queue_measurement(int unsigned wait_len, int unsigned echo_len);
    push_tick(CMD_START, 1'($urandom_range(1)));
    repeat (SEQ_TICKS) push_tick(CMD_TICK, 1'($urandom_range(1)));
    repeat (wait_len) push_tick(CMD_TICK, 1'b0);
    repeat (echo_len) push_tick(CMD_TICK, 1'b1);
    push_tick(CMD_TICK, 1'b0);
  endtask

  task automatic queue_random_sequence();
    int unsigned pick;
    int unsigned echo_len;
    pick = $urandom_range(99);
    if (pick < 70) begin
      // mostly short echoes, a few long ones
      pick = $urandom_range(99);
      if (pick < 70)      echo_len = $urandom_range(20, 1);
      else if (pick < 95) echo_len = $urandom_range(120, 21);
      else                echo_len = $urandom_range(600, 200);
      queue_measurement($urandom_range(6), echo_len);
      repeat ($urandom_range(2)) push_tick(CMD_TICK, 1'($urandom_range(1)));
    end else if (pick < 85) begin
      // broken measurement, the next start lands mid-flight
      push_tick(CMD_START, 1'($urandom_range(1)));
      case ($urandom_range(2))
        0: repeat ($urandom_range(SEQ_TICKS - 1))
             push_tick(CMD_TICK, 1'($urandom_range(1)));
        1: begin
          repeat (SEQ_TICKS) push_tick(CMD_TICK, 1'($urandom_range(1)));
          repeat ($urandom_range(30)) push_tick(CMD_TICK, 1'b0);  // echo never rises
        end
        default: begin
          repeat (SEQ_TICKS) push_tick(CMD_TICK, 1'($urandom_range(1)));
          repeat ($urandom_range(4)) push_tick(CMD_TICK, 1'b0);
          repeat ($urandom_range(30, 1)) push_tick(CMD_TICK, 1'b1);
        end
      endcase
      push_tick(CMD_START, 1'($urandom_range(1)));
    end else begin
      // noise: random starts and echo levels
      repeat ($urandom_range(10, 1))
        push_tick($urandom_range(99) < 20, 1'($urandom_range(1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned batch;
    int unsigned phase_end;
    int unsigned batch_start;
    int unsigned gap_tbl[4];
    int unsigned stall_tbl[4];
    batch     = 0;
    gap_tbl   = '{0, 50, 0, 12};
    stall_tbl = '{0, 0, 50, 12};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: ticks in idle, restart during pre-low, ignored echo during
    // the trigger sequence, then a one-tick echo (half count zero).
    push_tick(CMD_TICK, 1'b0);
    push_tick(CMD_TICK, 1'b1);
    push_tick(CMD_START, 1'b1);
    push_tick(CMD_TICK, 1'b1);
    push_tick(CMD_START, 1'b0);
    for (int i = 0; i < SEQ_TICKS; i++) push_tick(CMD_TICK, i[0]);
    push_tick(CMD_TICK, 1'b0);
    push_tick(CMD_TICK, 1'b1);
    push_tick(CMD_TICK, 1'b0);
    push_tick(CMD_TICK, 1'b1);

    // Random: four pacing phases, registers changed every batch
    for (int ph = 0; ph < 4; ph++) begin
      phase_end = items_queued + ITEM_TARGET / 4;
      while (items_queued < phase_end) begin
        wait_drained();
        gap_pct   = gap_tbl[ph];
        stall_pct = stall_tbl[ph];
        case (batch)
          0: set_config('1, '1);
          1: set_config('0, '0);
          2: set_config(SPEED_RESET, TIMEOUT_W'(20));
          default: begin
            case ($urandom_range(4))
              0: set_config(SPEED_RESET, TIMEOUT_RESET);
              1: set_config(SPEED_W'($urandom), TIMEOUT_W'($urandom_range(60)));
              2: set_config('1, TIMEOUT_W'($urandom_range(30)));
              3: set_config(SPEED_W'($urandom), TIMEOUT_W'($urandom));
              default: set_config(SPEED_W'($urandom_range(90000, 80000)),
                                  TIMEOUT_W'($urandom_range(300)));
            endcase
          end
        endcase
        batch++;
        batch_start = items_queued;
        while (items_queued < phase_end && tick_q.size() < BATCH_ITEMS)
          queue_random_sequence();
        // back the block up while the sender keeps offering
        if ((ph == 0 || ph == 2) && batch_start < phase_end - ITEM_TARGET / 8 &&
            items_queued >= phase_end - ITEM_TARGET / 8)
          hold_asks++;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d items (%0d starts) across four pacing phases and %0d register settings",
             items_taken, n_starts, n_configs);
    $display("Checked %0d results: %0d completed readings, %0d beyond timeout, %0d long hold-offs",
             n_results, n_done, n_far, hold_served);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
